FILE: rtl/mmcal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mmcal_pkg;

	localparam int SAMPLE_BITS_DEF     = 16;
	localparam int SCALE_FRAC_BITS_DEF = 14;
	localparam int COUNT_W             = 16;
	localparam int MIN_RANGE_W         = 16;
	localparam int SCALE_TOL_W         = 15;
	localparam int CFG_DATA_W          = 16;
	localparam int CFG_INDEX_W         = 1;

	localparam logic [MIN_RANGE_W-1:0] MIN_RANGE_RST = 16'd10;
	localparam logic [SCALE_TOL_W-1:0] SCALE_TOL_RST = 15'd3277;

	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_RANGE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_TOL = 1'b1;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_SETUP,
		ST_DIV,
		ST_STORE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic sum_en;
		logic setup_en;
		logic div_en;
		logic store_en;
	} ctl_t;

endpackage
`default_nettype wire

FILE: rtl/magnetometer_minmax_calibrator.sv
`timescale 1ns / 1ps
`default_nettype none
// Three-axis magnetometer min/max calibrator. A sample item (command 0) is taken
// on any cycle where start is high and busy is low; it updates the per-axis
// extremes in that same cycle and produces no result, so samples can stream at
// one per clock. A finish item (command 1) snapshots the run, clears the
// extremes and sample count, and raises busy while the three soft-iron scales
// are computed by one shared restoring divider that retires one quotient bit
// per cycle. Busy stays high until all three scales are stored; an axis scale
// forced to 1.0 or saturated skips the divider. In the last busy cycle done
// pulses for exactly one clock with the result on the output ports. There is
// no backpressure: the receiver must capture the result on that clock.
// Offsets are max+min (half-count units), scales are avg_range/range in
// unsigned Q2.SCALE_FRAC_BITS rounded half up and saturating. Configuration
// writes (cfg_write/cfg_index/cfg_data) take effect at once and are to be
// issued only while busy is low.
module magnetometer_minmax_calibrator #(
	parameter int SAMPLE_BITS     = mmcal_pkg::SAMPLE_BITS_DEF,
	parameter int SCALE_FRAC_BITS = mmcal_pkg::SCALE_FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                command,
	input  wire logic signed [SAMPLE_BITS-1:0]       mag_x,
	input  wire logic signed [SAMPLE_BITS-1:0]       mag_y,
	input  wire logic signed [SAMPLE_BITS-1:0]       mag_z,
	output logic                                     done,
	output logic signed [SAMPLE_BITS:0]              offset_x,
	output logic signed [SAMPLE_BITS:0]              offset_y,
	output logic signed [SAMPLE_BITS:0]              offset_z,
	output logic [SCALE_FRAC_BITS+1:0]               scale_x,
	output logic [SCALE_FRAC_BITS+1:0]               scale_y,
	output logic [SCALE_FRAC_BITS+1:0]               scale_z,
	output logic                                     range_ok,
	output logic                                     scale_ok,
	output logic [mmcal_pkg::COUNT_W-1:0]            sample_count,
	input  wire logic                                cfg_write,
	input  wire logic [mmcal_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [mmcal_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mmcal_pkg::*;

	localparam int W    = SAMPLE_BITS;
	localparam int F    = SCALE_FRAC_BITS;
	localparam int SW   = F + 2;               // scale width
	localparam int SUMW = W + 2;               // sum of three ranges, also 3*range
	localparam int DW   = W + 3;               // divisor 6*range
	localparam int NW   = W + F + 3;           // dividend (sum << (F+1)) + 3*range
	localparam int STW  = $clog2(F + 2);
	localparam int RW   = (W > MIN_RANGE_W) ? W : MIN_RANGE_W;
	localparam int TW   = (SW > SCALE_TOL_W) ? SW : SCALE_TOL_W;

	localparam logic signed [W-1:0] SAMP_MAX  = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SAMP_MIN  = {1'b1, {(W-1){1'b0}}};
	localparam logic [SW-1:0]       SCALE_ONE = SW'(1) << F;
	localparam logic [SW-1:0]       SCALE_MAX = {SW{1'b1}};
	localparam logic [COUNT_W-1:0]  COUNT_MAX = {COUNT_W{1'b1}};

	state_t state_q, state_d;
	ctl_t   ctl;

	// config
	logic [MIN_RANGE_W-1:0] min_range_q;
	logic [SCALE_TOL_W-1:0] scale_tol_q;

	// running extremes
	logic signed [W-1:0] mag   [3];
	logic signed [W-1:0] min_q [3];
	logic signed [W-1:0] max_q [3];
	logic [COUNT_W-1:0]  count_q;

	// run snapshot
	logic [W-1:0]        range_q [3];
	logic signed [W:0]   off_q   [3];
	logic [COUNT_W-1:0]  snap_count_q;
	logic [SUMW-1:0]     sum_q;
	logic                rok_q;
	logic                sok_q;
	logic [SW-1:0]       scale_q [3];

	// divider
	logic [1:0]          axis_q;
	logic [STW-1:0]      step_q;
	logic [DW-1:0]       den_q;
	logic [DW-1:0]       rem_q;
	logic [SW-1:0]       nlo_q;
	logic [SW-1:0]       quot_q;

	logic                accept;
	logic                special;

	logic [W-1:0]        range_d [3];
	logic signed [W:0]   off_d   [3];
	logic [W-1:0]        r_sel;
	logic [SUMW-1:0]     r3;
	logic [DW-1:0]       den_d;
	logic [NW-1:0]       num_d;
	logic [W:0]          nhi;
	logic                sat;
	logic [DW:0]         trial;
	logic [DW:0]         trial_diff;
	logic                ge;
	logic [SW-1:0]       dev;

	assign accept = start && !busy;
	assign mag[0] = mag_x;
	assign mag[1] = mag_y;
	assign mag[2] = mag_z;

	// snapshot of each axis at finish; an empty run reads as zero span and offset
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [W:0] hi_e;
			logic signed [W:0] lo_e;
			logic signed [W:0] diff;
			hi_e = {max_q[i][W-1], max_q[i]};
			lo_e = {min_q[i][W-1], min_q[i]};
			diff = hi_e - lo_e;
			range_d[i] = (count_q == '0) ? '0 : diff[W-1:0];
			off_d[i]   = (count_q == '0) ? '0 : (hi_e + lo_e);
		end
	end

	// per-axis divider setup: N = (sum << (F+1)) + 3r, D = 6r
	always_comb begin
		r_sel   = range_q[axis_q];
		r3      = SUMW'(r_sel) + (SUMW'(r_sel) << 1);
		den_d   = {r3, 1'b0};
		num_d   = (NW'(sum_q) << (F + 1)) + NW'(r3);
		nhi     = num_d[NW-1:F+2];
		// quotient would not fit in SW bits (covers D == 0 too)
		sat     = DW'(nhi) >= den_d;
		special = (sum_q == '0) || sat;
	end

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial      = {rem_q, nlo_q[SW-1]};
		trial_diff = trial - {1'b0, den_q};
		ge         = trial >= {1'b0, den_q};
	end

	always_comb begin
		dev = (quot_q >= SCALE_ONE) ? (quot_q - SCALE_ONE) : (SCALE_ONE - quot_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && command == CMD_FINISH) state_d = ST_SUM;
			end
			ST_SUM:   state_d = ST_SETUP;
			ST_SETUP: state_d = special ? ST_STORE : ST_DIV;
			ST_DIV: begin
				if (step_q == STW'(F + 1)) state_d = ST_STORE;
			end
			ST_STORE: state_d = (axis_q == 2'd2) ? ST_DONE : ST_SETUP;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE:  ctl.busy = 1'b0;
			ST_SUM: begin
				ctl.busy   = 1'b1;
				ctl.sum_en = 1'b1;
			end
			ST_SETUP: begin
				ctl.busy     = 1'b1;
				ctl.setup_en = 1'b1;
			end
			ST_DIV: begin
				ctl.busy   = 1'b1;
				ctl.div_en = 1'b1;
			end
			ST_STORE: begin
				ctl.busy     = 1'b1;
				ctl.store_en = 1'b1;
			end
			ST_DONE: begin
				ctl.busy = 1'b1;
				ctl.done = 1'b1;
			end
			default:  ctl = '0;
		endcase
	end

	assign busy = ctl.busy;
	assign done = ctl.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q <= MIN_RANGE_RST;
			scale_tol_q <= SCALE_TOL_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_MIN_RANGE: min_range_q <= cfg_data[MIN_RANGE_W-1:0];
				CFG_SCALE_TOL: scale_tol_q <= cfg_data[SCALE_TOL_W-1:0];
				default:       ;
			endcase
		end
	end

	// running min/max and sample count; finish clears them for a new run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				min_q[i] <= SAMP_MAX;
				max_q[i] <= SAMP_MIN;
			end
			count_q <= '0;
		end else if (accept) begin
			if (command == CMD_SAMPLE) begin
				for (int i = 0; i < 3; i++) begin
					if (mag[i] < min_q[i]) min_q[i] <= mag[i];
					if (mag[i] > max_q[i]) max_q[i] <= mag[i];
				end
				if (count_q != COUNT_MAX) count_q <= count_q + 1'b1;
			end else begin
				for (int i = 0; i < 3; i++) begin
					min_q[i] <= SAMP_MAX;
					max_q[i] <= SAMP_MIN;
				end
				count_q <= '0;
			end
		end
	end

	// snapshot, flags and divider datapath
	always_ff @(posedge clk) begin
		if (accept && command == CMD_FINISH) begin
			for (int i = 0; i < 3; i++) begin
				range_q[i] <= range_d[i];
				off_q[i]   <= off_d[i];
			end
			snap_count_q <= count_q;
		end
		if (ctl.sum_en) begin
			sum_q  <= SUMW'(range_q[0]) + SUMW'(range_q[1]) + SUMW'(range_q[2]);
			rok_q  <= (RW'(range_q[0]) >= RW'(min_range_q)) &&
				  (RW'(range_q[1]) >= RW'(min_range_q)) &&
				  (RW'(range_q[2]) >= RW'(min_range_q));
			sok_q  <= 1'b1;
			axis_q <= 2'd0;
		end
		if (ctl.setup_en) begin
			den_q  <= den_d;
			rem_q  <= DW'(nhi);
			nlo_q  <= num_d[SW-1:0];
			step_q <= '0;
			if (sum_q == '0) begin
				quot_q <= SCALE_ONE;
			end else if (sat) begin
				quot_q <= SCALE_MAX;
			end
		end
		if (ctl.div_en) begin
			rem_q  <= ge ? trial_diff[DW-1:0] : trial[DW-1:0];
			nlo_q  <= {nlo_q[SW-2:0], 1'b0};
			quot_q <= {quot_q[SW-2:0], ge};
			step_q <= step_q + 1'b1;
		end
		if (ctl.store_en) begin
			scale_q[axis_q] <= quot_q;
			if (TW'(dev) > TW'(scale_tol_q)) sok_q <= 1'b0;
			// one flat axis with motion on the others
			if (sum_q != '0 && r_sel == '0) sok_q <= 1'b0;
			axis_q <= axis_q + 2'd1;
		end
	end

	assign offset_x     = off_q[0];
	assign offset_y     = off_q[1];
	assign offset_z     = off_q[2];
	assign scale_x      = scale_q[0];
	assign scale_y      = scale_q[1];
	assign scale_z      = scale_q[2];
	assign range_ok     = rok_q;
	assign scale_ok     = sok_q;
	assign sample_count = snap_count_q;

	// finish item always leads to the busy phase
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_FINISH) |=> busy)
		else $error("finish item did not start computation");

	// block is ready again right after the result strobe
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy still high after result");

	// partial remainder stays below the divisor while dividing
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder out of range");

	// all three axes are stored before the strobe
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (axis_q == 2'd3))
		else $error("result strobe before all axes were done");

endmodule
`default_nettype wire
